// ===== rtl/feeder_fire_sequencer_jam_guard_unit_defines.svh =====
// Assertion macros for the feeder fire sequencer RTL.
`ifndef FEEDER_FIRE_SEQUENCER_JAM_GUARD_UNIT_DEFINES_SVH
`define FEEDER_FIRE_SEQUENCER_JAM_GUARD_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FFSJG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FFSJG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ffsjg_pkg.sv =====
// Shared types, widths, codes and reset values of the feeder fire sequencer.
package ffsjg_pkg;

  // Default sizes of the internal state
  localparam int ANGLE_BITS_DEF = 16;
  localparam int TICK_BITS_DEF  = 16;
  localparam int SHOT_BITS_DEF  = 8;

  // Field widths on the ports
  localparam int ANGLE_W   = 16;
  localparam int CURRENT_W = 16;
  localparam int MA_W      = 15;
  localparam int TICKCFG_W = 16;
  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JAM_ENABLE      = 3'd0,
    REG_JAM_THRESHOLD   = 3'd1,
    REG_JAM_SUSPECT     = 3'd2,
    REG_JAM_RECOVER     = 3'd3,
    REG_RELEASE_THRESH  = 3'd4,
    REG_SHOT_PERIOD     = 3'd5,
    REG_BURST_COUNT     = 3'd6,
    REG_TOOTH_STEP      = 3'd7
  } cfg_reg_t;

  // Register values after reset
  localparam logic                 RST_JAM_ENABLE     = 1'b1;
  localparam logic [MA_W-1:0]      RST_JAM_THRESHOLD  = 15'd10000;
  localparam logic [TICKCFG_W-1:0] RST_JAM_SUSPECT    = 16'd500;
  localparam logic [TICKCFG_W-1:0] RST_JAM_RECOVER    = 16'd300;
  localparam logic [MA_W-1:0]      RST_RELEASE_THRESH = 15'd20000;
  localparam logic [TICKCFG_W-1:0] RST_SHOT_PERIOD    = 16'd100;
  localparam logic [COUNT_W-1:0]   RST_BURST_COUNT    = 8'd3;
  localparam logic [ANGLE_W-1:0]   RST_TOOTH_STEP     = 16'd8192;

  // Operating modes
  localparam logic [1:0] MODE_SAFE       = 2'd0;
  localparam logic [1:0] MODE_SINGLE     = 2'd1;
  localparam logic [1:0] MODE_BURST      = 2'd2;
  localparam logic [1:0] MODE_CONTINUOUS = 2'd3;

  typedef struct packed {
    logic                 jam_enable;
    logic [MA_W-1:0]      jam_threshold_ma;
    logic [TICKCFG_W-1:0] jam_suspect_ticks;
    logic [TICKCFG_W-1:0] jam_recover_ticks;
    logic [MA_W-1:0]      release_threshold_ma;
    logic [TICKCFG_W-1:0] shot_period_ticks;
    logic [COUNT_W-1:0]   burst_count;
    logic [ANGLE_W-1:0]   tooth_step;
  } ffsjg_cfg_t;

  typedef struct packed {
    logic [1:0]                  mode;
    logic                        ready_req;
    logic                        fire;
    logic [ANGLE_W-1:0]          measured_angle;
    logic signed [CURRENT_W-1:0] motor_current_ma;
  } ffsjg_in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_setpoint;
    logic               relax;
    logic [1:0]         run_phase;
    logic [1:0]         jam_phase;
    logic               jam_flag;
    logic [COUNT_W-1:0] shots_left;
    logic               endless;
  } ffsjg_out_item_t;

endpackage

// ===== rtl/ffsjg_if.sv =====
// Channel interfaces: tick input, result output and configuration write.
interface ffsjg_in_if import ffsjg_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic                        ready_req;
  logic                        fire;
  logic [ANGLE_W-1:0]          measured_angle;
  logic signed [CURRENT_W-1:0] motor_current_ma;

  modport source (output valid, mode, ready_req, fire, measured_angle, motor_current_ma,
                  input ready);
  modport sink (input valid, mode, ready_req, fire, measured_angle, motor_current_ma,
                output ready);
endinterface

interface ffsjg_out_if import ffsjg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_setpoint;
  logic               relax;
  logic [1:0]         run_phase;
  logic [1:0]         jam_phase;
  logic               jam_flag;
  logic [COUNT_W-1:0] shots_left;
  logic               endless;

  modport source (output valid, angle_setpoint, relax, run_phase, jam_phase, jam_flag,
                  shots_left, endless, input ready);
  modport sink (input valid, angle_setpoint, relax, run_phase, jam_phase, jam_flag,
                shots_left, endless, output ready);
endinterface

interface ffsjg_cfg_if import ffsjg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ffsjg_cfg_regs.sv =====
// Configuration register file of the feeder fire sequencer.
module ffsjg_cfg_regs import ffsjg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ffsjg_cfg_if.sink   cfg_ch,
  output ffsjg_cfg_t  cfg
);

  ffsjg_cfg_t cfg_r;

  // Always take a write
  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  // Store the addressed register, cut to its width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jam_enable           <= RST_JAM_ENABLE;
      cfg_r.jam_threshold_ma     <= RST_JAM_THRESHOLD;
      cfg_r.jam_suspect_ticks    <= RST_JAM_SUSPECT;
      cfg_r.jam_recover_ticks    <= RST_JAM_RECOVER;
      cfg_r.release_threshold_ma <= RST_RELEASE_THRESH;
      cfg_r.shot_period_ticks    <= RST_SHOT_PERIOD;
      cfg_r.burst_count          <= RST_BURST_COUNT;
      cfg_r.tooth_step           <= RST_TOOTH_STEP;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_JAM_ENABLE:     cfg_r.jam_enable           <= cfg_ch.data[0];
        REG_JAM_THRESHOLD:  cfg_r.jam_threshold_ma     <= cfg_ch.data[MA_W-1:0];
        REG_JAM_SUSPECT:    cfg_r.jam_suspect_ticks    <= cfg_ch.data[TICKCFG_W-1:0];
        REG_JAM_RECOVER:    cfg_r.jam_recover_ticks    <= cfg_ch.data[TICKCFG_W-1:0];
        REG_RELEASE_THRESH: cfg_r.release_threshold_ma <= cfg_ch.data[MA_W-1:0];
        REG_SHOT_PERIOD:    cfg_r.shot_period_ticks    <= cfg_ch.data[TICKCFG_W-1:0];
        REG_BURST_COUNT:    cfg_r.burst_count          <= cfg_ch.data[COUNT_W-1:0];
        REG_TOOTH_STEP:     cfg_r.tooth_step           <= cfg_ch.data[ANGLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/ffsjg_seq.sv =====
// Per-tick update of the run sequencer and jam guard, with the result register.
`include "feeder_fire_sequencer_jam_guard_unit_defines.svh"

module ffsjg_seq import ffsjg_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int TICK_BITS  = TICK_BITS_DEF,
  parameter int SHOT_BITS  = SHOT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  ffsjg_in_item_t  item,
  input  ffsjg_cfg_t      cfg,
  output ffsjg_out_item_t res
);

  localparam int CMP_W = (TICK_BITS > TICKCFG_W) ? TICK_BITS : TICKCFG_W;

  typedef logic [ANGLE_BITS-1:0] angle_t;
  typedef logic [TICK_BITS-1:0]  tick_t;
  typedef logic [SHOT_BITS-1:0]  shot_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  // One radian as a fraction of a turn, rounded
  localparam logic [63:0] ONE_RAD_WIDE =
    ((64'd1 << ANGLE_BITS) * 64'd500000000 + 64'd1570796327) / 64'd3141592654;
  localparam angle_t ONE_RAD  = angle_t'(ONE_RAD_WIDE);
  localparam tick_t  TICK_MAX = '1;

  typedef enum logic [1:0] {
    RUN_IDLE  = 2'd0,
    RUN_READY = 2'd1,
    RUN_FIRE  = 2'd2
  } run_state_t;

  typedef enum logic [1:0] {
    G_NORMAL  = 2'd0,
    G_SUSPECT = 2'd1,
    G_CONFIRM = 2'd2,
    G_HANDLE  = 2'd3
  } guard_state_t;

  run_state_t      run_r,          run_nxt;
  guard_state_t    guard_r,        guard_nxt;
  angle_t          hold_r,         hold_nxt;
  angle_t          target_r,       target_nxt;
  shot_t           pending_r,      pending_nxt;
  logic            endless_r,      endless_nxt;
  tick_t           since_shot_r,   since_shot_nxt;
  tick_t           guard_timer_r,  guard_timer_nxt;
  logic            jam_seen_r,     jam_seen_nxt;
  logic            prev_fire_r,    prev_fire_nxt;
  ffsjg_out_item_t res_r,          res_nxt;

  angle_t                      meas;
  angle_t                      tooth;
  logic signed [CURRENT_W-1:0] cur;
  logic signed [CURRENT_W-1:0] thr_s;
  logic signed [CURRENT_W-1:0] rel_s;
  angle_t                      win_diff;
  logic                        shot_go;
  logic                        seq_run;
  logic                        recover_chk;

  assign meas  = angle_t'(item.measured_angle);
  assign tooth = angle_t'(cfg.tooth_step);
  assign cur   = item.motor_current_ma;
  assign thr_s = $signed({1'b0, cfg.jam_threshold_ma});
  assign rel_s = $signed({1'b0, cfg.release_threshold_ma});

  // Compute the whole tick: timers, guard, sequencer, recovery, result
  always_comb begin
    run_nxt         = run_r;
    guard_nxt       = guard_r;
    hold_nxt        = hold_r;
    target_nxt      = target_r;
    pending_nxt     = pending_r;
    endless_nxt     = endless_r;
    jam_seen_nxt    = jam_seen_r;
    prev_fire_nxt   = prev_fire_r;
    seq_run         = 1'b0;
    recover_chk     = 1'b0;

    // Advance both saturating tick counters
    since_shot_nxt  = (since_shot_r == TICK_MAX) ? since_shot_r : since_shot_r + tick_t'(1);
    guard_timer_nxt = (guard_timer_r == TICK_MAX) ? guard_timer_r
                                                  : guard_timer_r + tick_t'(1);

    // Jam guard ahead of the sequencer
    if (!cfg.jam_enable) begin
      guard_nxt    = G_NORMAL;
      jam_seen_nxt = 1'b0;
      seq_run      = 1'b1;
    end else begin
      case (guard_r)
        G_NORMAL: begin
          if (cur > thr_s) begin
            guard_nxt       = G_SUSPECT;
            guard_timer_nxt = '0;
          end
          seq_run = 1'b1;
        end
        G_SUSPECT: begin
          if (cur < thr_s) begin
            guard_nxt = G_NORMAL;
          end else if (cmp_t'(guard_timer_nxt) >= cmp_t'(cfg.jam_suspect_ticks)) begin
            jam_seen_nxt = 1'b1;
            guard_nxt    = G_CONFIRM;
          end else begin
            seq_run = 1'b1;
          end
        end
        default: begin
          // Confirmed jam: drop shots and back off one tooth behind the feeder
          if (guard_r == G_CONFIRM) begin
            pending_nxt     = '0;
            endless_nxt     = 1'b0;
            target_nxt      = meas - tooth;
            guard_nxt       = G_HANDLE;
            guard_timer_nxt = '0;
          end
          seq_run     = 1'b1;
          recover_chk = 1'b1;
        end
      endcase
    end

    // Shot check on the state as the sequencer sees it
    win_diff = target_nxt - meas;
    shot_go  = (pending_nxt != '0 || endless_nxt) &&
               (cmp_t'(since_shot_nxt) >= cmp_t'(cfg.shot_period_ticks)) &&
               item.fire && (win_diff[ANGLE_BITS-1] || win_diff <= ONE_RAD);

    // Run sequencer
    if (seq_run) begin
      if (item.mode == MODE_SAFE) begin
        hold_nxt   = meas;
        target_nxt = meas;
      end else begin
        case (run_r)
          RUN_IDLE: begin
            if (item.ready_req) begin
              run_nxt     = RUN_READY;
              pending_nxt = '0;
              endless_nxt = 1'b0;
            end
          end
          RUN_READY: begin
            if (shot_go) begin
              since_shot_nxt = '0;
              target_nxt     = target_nxt + tooth;
              if (!endless_nxt) begin
                pending_nxt = pending_nxt - shot_t'(1);
              end
            end
            if (!item.ready_req) begin
              run_nxt = RUN_IDLE;
            end else if (!prev_fire_r && item.fire) begin
              run_nxt     = RUN_FIRE;
              pending_nxt = '0;
              endless_nxt = 1'b0;
              if (item.mode == MODE_SINGLE) begin
                pending_nxt = shot_t'(1);
              end else if (item.mode == MODE_BURST) begin
                pending_nxt = shot_t'(cfg.burst_count);
              end else begin
                endless_nxt = 1'b1;
              end
            end
          end
          RUN_FIRE: begin
            if (shot_go) begin
              since_shot_nxt = '0;
              target_nxt     = target_nxt + tooth;
              if (!endless_nxt) begin
                pending_nxt = pending_nxt - shot_t'(1);
              end
            end
            if (!item.fire) begin
              run_nxt     = RUN_READY;
              hold_nxt    = meas;
              pending_nxt = '0;
              endless_nxt = 1'b0;
            end
          end
          default: begin
            run_nxt = RUN_IDLE;
          end
        endcase
      end
      prev_fire_nxt = item.fire;
    end

    // Leave jam handling once the recover time has passed and the current is below the release threshold
    if (recover_chk && (cmp_t'(guard_timer_nxt) >= cmp_t'(cfg.jam_recover_ticks)) &&
        (cur < rel_s)) begin
      guard_nxt = G_NORMAL;
    end

    // Assemble the result
    res_nxt.angle_setpoint = (run_nxt == RUN_FIRE) ? ANGLE_W'(target_nxt)
                                                   : ANGLE_W'(hold_nxt);
    res_nxt.relax          = (item.mode == MODE_SAFE);
    res_nxt.run_phase      = run_nxt;
    res_nxt.jam_phase      = guard_nxt;
    res_nxt.jam_flag       = jam_seen_nxt;
    res_nxt.shots_left     = COUNT_W'(pending_nxt);
    res_nxt.endless        = endless_nxt;
  end

  // Hold state and the result register; advance once per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r         <= RUN_IDLE;
      guard_r       <= G_NORMAL;
      hold_r        <= '0;
      target_r      <= '0;
      pending_r     <= '0;
      endless_r     <= 1'b0;
      since_shot_r  <= TICK_MAX;
      guard_timer_r <= '0;
      jam_seen_r    <= 1'b0;
      prev_fire_r   <= 1'b0;
    end else if (step_en) begin
      run_r         <= run_nxt;
      guard_r       <= guard_nxt;
      hold_r        <= hold_nxt;
      target_r      <= target_nxt;
      pending_r     <= pending_nxt;
      endless_r     <= endless_nxt;
      since_shot_r  <= since_shot_nxt;
      guard_timer_r <= guard_timer_nxt;
      jam_seen_r    <= jam_seen_nxt;
      prev_fire_r   <= prev_fire_nxt;
      res_r         <= res_nxt;
    end
  end

  assign res = res_r;

  // Continuous firing never carries a shot count alongside
  `FFSJG_ASSERT_NOW(a_endless_no_count, endless_r, pending_r == '0, "endless with shots pending")
  // Detection off forces the guard back to normal and clears the flag
  `FFSJG_ASSERT_NEXT(a_jam_off_clears, step_en && !cfg.jam_enable,
    guard_r == G_NORMAL && !jam_seen_r, "guard not cleared with detection off")
  // A confirmed jam moves to handling (or straight out) with a fresh timer
  `FFSJG_ASSERT_NEXT(a_confirm_to_handle, step_en && cfg.jam_enable && guard_r == G_CONFIRM,
    (guard_r == G_HANDLE || guard_r == G_NORMAL) && guard_timer_r == '0,
    "confirmed jam did not enter handling")

endmodule

// ===== rtl/feeder_fire_sequencer_jam_guard_unit.sv =====
// Feeder fire sequencer with jam guard: takes one control tick per item and returns one
// result per tick. Items are taken at one per clock cycle, back to back, while the
// result output is not stalled. The input register holds the tick, and the single
// combinational tick update loads the result register from it once the result slot is
// free; the result register then offers the result on the output. While a result waits
// on a stalled output, the input register takes one more item and then holds the input
// ready low until the result transfer. The configuration port is always ready and a
// written register applies from the next tick; write it only while no tick is in flight.
module feeder_fire_sequencer_jam_guard_unit import ffsjg_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int TICK_BITS  = TICK_BITS_DEF,
  parameter int SHOT_BITS  = SHOT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ffsjg_cfg_if.sink   cfg_ch,
  ffsjg_in_if.sink    in_ch,
  ffsjg_out_if.source out_ch
);

  ffsjg_cfg_t      cfg;
  ffsjg_in_item_t  in_item_r;
  ffsjg_out_item_t res;
  logic            in_valid_r;
  logic            out_valid_r;
  logic            out_free;
  logic            advance;

  // Move the held item into the result register when that slot frees up
  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || advance;

  // Track occupancy of the input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Capture the input payload on transfer
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.mode             <= in_ch.mode;
      in_item_r.ready_req        <= in_ch.ready_req;
      in_item_r.fire             <= in_ch.fire;
      in_item_r.measured_angle   <= in_ch.measured_angle;
      in_item_r.motor_current_ma <= in_ch.motor_current_ma;
    end
  end

  ffsjg_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ffsjg_seq #(
    .ANGLE_BITS (ANGLE_BITS),
    .TICK_BITS  (TICK_BITS),
    .SHOT_BITS  (SHOT_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Drive the result channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.angle_setpoint = res.angle_setpoint;
  assign out_ch.relax          = res.relax;
  assign out_ch.run_phase      = res.run_phase;
  assign out_ch.jam_phase      = res.jam_phase;
  assign out_ch.jam_flag       = res.jam_flag;
  assign out_ch.shots_left     = res.shots_left;
  assign out_ch.endless        = res.endless;

endmodule

// ===== test/tb_feeder_fire_sequencer_jam_guard_unit.sv =====
// Self-checking testbench for the feeder fire sequencer with jam guard.
`timescale 1ns / 100ps

module tb_feeder_fire_sequencer_jam_guard_unit;
  import ffsjg_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam longint unsigned ONE_RAD_WIDE =
    ((64'd1 << ANGLE_W) * 64'd500000000 + 64'd1570796327) / 64'd3141592654;
  localparam logic [ANGLE_W-1:0] ONE_RAD = ONE_RAD_WIDE[ANGLE_W-1:0];
  localparam logic [15:0] TICK_SAT = 16'hFFFF;

  typedef enum logic [1:0] {RUN_IDLE, RUN_READY, RUN_FIRE} run_state_t;
  typedef enum logic [1:0] {GUARD_NORMAL, GUARD_SUSPECT, GUARD_CONFIRM, GUARD_HANDLE}
    guard_state_t;

  logic clk;
  logic rst_n;

  ffsjg_cfg_if cfg_ch ();
  ffsjg_in_if  in_ch ();
  ffsjg_out_if out_ch ();

  feeder_fire_sequencer_jam_guard_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted sequencer and guard state, plus the register shadow
  ffsjg_cfg_t         shadow_cfg;
  run_state_t         p_run;
  guard_state_t       p_guard;
  logic [ANGLE_W-1:0] p_hold;
  logic [ANGLE_W-1:0] p_target;
  logic [COUNT_W-1:0] p_pending;
  logic               p_endless;
  logic [15:0]        p_since;
  logic [15:0]        p_guard_timer;
  logic               p_jam_seen;
  logic               p_prev_fire;

  ffsjg_out_item_t feeder_results_q[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_left = 0;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL feeder_fire_sequencer_jam_guard_unit");
      $finish;
    end
  end

  function automatic void reset_feeder_model();
    shadow_cfg.jam_enable           = RST_JAM_ENABLE;
    shadow_cfg.jam_threshold_ma     = RST_JAM_THRESHOLD;
    shadow_cfg.jam_suspect_ticks    = RST_JAM_SUSPECT;
    shadow_cfg.jam_recover_ticks    = RST_JAM_RECOVER;
    shadow_cfg.release_threshold_ma = RST_RELEASE_THRESH;
    shadow_cfg.shot_period_ticks    = RST_SHOT_PERIOD;
    shadow_cfg.burst_count          = RST_BURST_COUNT;
    shadow_cfg.tooth_step           = RST_TOOTH_STEP;
    p_run         = RUN_IDLE;
    p_guard       = GUARD_NORMAL;
    p_hold        = '0;
    p_target      = '0;
    p_pending     = '0;
    p_endless     = 1'b0;
    p_since       = TICK_SAT;
    p_guard_timer = '0;
    p_jam_seen    = 1'b0;
    p_prev_fire   = 1'b0;
  endfunction

  // Advance the target one tooth when a shot is due and the feeder is close enough
  function automatic void fire_shot_if_due(logic fire, logic [ANGLE_W-1:0] meas);
    logic [ANGLE_W-1:0] lead;
    lead = p_target - meas;
    if (p_pending == '0 && !p_endless) return;
    if (p_since >= shadow_cfg.shot_period_ticks && fire &&
        (lead[ANGLE_W-1] || lead <= ONE_RAD)) begin
      p_since  = '0;
      p_target = p_target + shadow_cfg.tooth_step;
      if (!p_endless) p_pending = p_pending - 1'b1;
    end
  endfunction

  function automatic void run_sequencer(ffsjg_in_item_t it);
    if (it.mode == MODE_SAFE) begin
      p_hold   = it.measured_angle;
      p_target = it.measured_angle;
    end else begin
      case (p_run)
        RUN_IDLE: begin
          if (it.ready_req) begin
            p_run     = RUN_READY;
            p_pending = '0;
            p_endless = 1'b0;
          end
        end
        RUN_READY: begin
          fire_shot_if_due(it.fire, it.measured_angle);
          if (!it.ready_req) begin
            p_run = RUN_IDLE;
          end else if (!p_prev_fire && it.fire) begin
            p_run     = RUN_FIRE;
            p_pending = '0;
            p_endless = 1'b0;
            if (it.mode == MODE_SINGLE) p_pending = 1;
            else if (it.mode == MODE_BURST) p_pending = shadow_cfg.burst_count;
            else p_endless = 1'b1;
          end
        end
        RUN_FIRE: begin
          fire_shot_if_due(it.fire, it.measured_angle);
          if (!it.fire) begin
            p_run     = RUN_READY;
            p_hold    = it.measured_angle;
            p_pending = '0;
            p_endless = 1'b0;
          end
        end
        default: p_run = RUN_IDLE;
      endcase
    end
    p_prev_fire = it.fire;
  endfunction

  // One control tick: counters, jam guard, sequencer, then the result
  function automatic ffsjg_out_item_t step_feeder(ffsjg_in_item_t it);
    int cur;
    int thr;
    int rel;
    ffsjg_out_item_t r;
    cur = int'($signed(it.motor_current_ma));
    thr = int'(shadow_cfg.jam_threshold_ma);
    rel = int'(shadow_cfg.release_threshold_ma);
    if (p_since != TICK_SAT) p_since++;
    if (p_guard_timer != TICK_SAT) p_guard_timer++;

    if (!shadow_cfg.jam_enable) begin
      p_guard    = GUARD_NORMAL;
      p_jam_seen = 1'b0;
      run_sequencer(it);
    end else if (p_guard == GUARD_NORMAL) begin
      if (cur > thr) begin
        p_guard       = GUARD_SUSPECT;
        p_guard_timer = '0;
      end
      run_sequencer(it);
    end else if (p_guard == GUARD_SUSPECT) begin
      if (cur < thr) begin
        p_guard = GUARD_NORMAL;
      end else if (p_guard_timer >= shadow_cfg.jam_suspect_ticks) begin
        p_jam_seen = 1'b1;
        p_guard    = GUARD_CONFIRM;
      end else begin
        run_sequencer(it);
      end
    end else begin
      // Confirmed jam: drop the shots and back the target off one tooth
      if (p_guard == GUARD_CONFIRM) begin
        p_pending     = '0;
        p_endless     = 1'b0;
        p_target      = it.measured_angle - shadow_cfg.tooth_step;
        p_guard       = GUARD_HANDLE;
        p_guard_timer = '0;
      end
      run_sequencer(it);
      if (p_guard_timer >= shadow_cfg.jam_recover_ticks && cur < rel) p_guard = GUARD_NORMAL;
    end

    r.angle_setpoint = (p_run == RUN_FIRE) ? p_target : p_hold;
    r.relax          = (it.mode == MODE_SAFE);
    r.run_phase      = p_run;
    r.jam_phase      = p_guard;
    r.jam_flag       = p_jam_seen;
    r.shots_left     = p_pending;
    r.endless        = p_endless;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver: random or forced hold-off, driven at the falling edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    ffsjg_out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (feeder_results_q.size() == 0) begin
        $error("result transfer with no prediction waiting");
        mismatch_count++;
      end else begin
        want = feeder_results_q.pop_front();
        check_field("angle_setpoint", want.angle_setpoint, out_ch.angle_setpoint);
        check_field("relax", want.relax, out_ch.relax);
        check_field("run_phase", want.run_phase, out_ch.run_phase);
        check_field("jam_phase", want.jam_phase, out_ch.jam_phase);
        check_field("jam_flag", want.jam_flag, out_ch.jam_flag);
        check_field("shots_left", want.shots_left, out_ch.shots_left);
        check_field("endless", want.endless, out_ch.endless);
      end
    end
  end

  // Offer one tick, idling at random first; predict on the transfer
  task automatic send_tick(ffsjg_in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.mode             <= it.mode;
    in_ch.ready_req        <= it.ready_req;
    in_ch.fire             <= it.fire;
    in_ch.measured_angle   <= it.measured_angle;
    in_ch.motor_current_ma <= it.motor_current_ma;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    feeder_results_q.push_back(step_feeder(it));
  endtask

  task automatic send_cmd(logic [1:0] md, logic rq, logic fr, logic [ANGLE_W-1:0] ang,
                          logic [CURRENT_W-1:0] cur);
    ffsjg_in_item_t it;
    it.mode             = md;
    it.ready_req        = rq;
    it.fire             = fr;
    it.measured_angle   = ang;
    it.motor_current_ma = cur;
    send_tick(it);
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic settle_feeder();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (feeder_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_JAM_ENABLE:     shadow_cfg.jam_enable           = val[0];
      REG_JAM_THRESHOLD:  shadow_cfg.jam_threshold_ma     = val[MA_W-1:0];
      REG_JAM_SUSPECT:    shadow_cfg.jam_suspect_ticks    = val;
      REG_JAM_RECOVER:    shadow_cfg.jam_recover_ticks    = val;
      REG_RELEASE_THRESH: shadow_cfg.release_threshold_ma = val[MA_W-1:0];
      REG_SHOT_PERIOD:    shadow_cfg.shot_period_ticks    = val;
      REG_BURST_COUNT:    shadow_cfg.burst_count          = val[COUNT_W-1:0];
      REG_TOOTH_STEP:     shadow_cfg.tooth_step           = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_feeder(ffsjg_cfg_t s);
    settle_feeder();
    write_reg(REG_JAM_ENABLE, 16'(s.jam_enable));
    write_reg(REG_JAM_THRESHOLD, 16'(s.jam_threshold_ma));
    write_reg(REG_JAM_SUSPECT, s.jam_suspect_ticks);
    write_reg(REG_JAM_RECOVER, s.jam_recover_ticks);
    write_reg(REG_RELEASE_THRESH, 16'(s.release_threshold_ma));
    write_reg(REG_SHOT_PERIOD, s.shot_period_ticks);
    write_reg(REG_BURST_COUNT, 16'(s.burst_count));
    write_reg(REG_TOOTH_STEP, s.tooth_step);
  endtask

  function automatic ffsjg_cfg_t make_settings(logic en, int thr, int sus, int rec, int rel,
                                               int per, int burst, int tooth);
    ffsjg_cfg_t s;
    s.jam_enable           = en;
    s.jam_threshold_ma     = MA_W'(thr);
    s.jam_suspect_ticks    = TICKCFG_W'(sus);
    s.jam_recover_ticks    = TICKCFG_W'(rec);
    s.release_threshold_ma = MA_W'(rel);
    s.shot_period_ticks    = TICKCFG_W'(per);
    s.burst_count          = COUNT_W'(burst);
    s.tooth_step           = ANGLE_W'(tooth);
    return s;
  endfunction

  function automatic ffsjg_cfg_t random_settings();
    return make_settings($urandom_range(3) != 0, $urandom_range(4000), $urandom_range(8),
                         $urandom_range(12), $urandom_range(8000, 500), $urandom_range(6),
                         $urandom_range(6), $urandom_range(65535));
  endfunction

  // Shooting sessions: arm, press and release fire, with the feeder tracking the target
  // and occasional current spikes long enough to trip the guard
  task automatic drive_shooting(int n_items);
    int left;
    int jam_left;
    int c;
    int pick;
    int k;
    logic [1:0] md;
    logic rq;
    logic fr;
    logic [ANGLE_W-1:0] ang;
    left = 0;
    jam_left = 0;
    md = MODE_SINGLE;
    rq = 1'b0;
    fr = 1'b0;
    for (k = 0; k < n_items; k++) begin
      if (left == 0) begin
        md   = ($urandom_range(9) == 0) ? MODE_SAFE : 2'($urandom_range(3, 1));
        left = $urandom_range(40, 5);
        rq   = 1'b1;
        fr   = 1'b0;
      end
      left--;
      if ($urandom_range(99) < 15) fr = ~fr;
      if ($urandom_range(99) < 4) rq = ~rq;
      if ($urandom_range(99) < 3) md = 2'($urandom);
      if ($urandom_range(99) < 15) ang = 16'($urandom);
      else ang = p_target + 16'($urandom_range(2000)) - 16'($urandom_range(12000));
      if (jam_left > 0) begin
        jam_left--;
        c = int'(shadow_cfg.jam_threshold_ma) + int'($urandom_range(2000));
        if (c > 32767) c = 32767;
      end else begin
        if ($urandom_range(99) < 4) jam_left = $urandom_range(20, 1);
        pick = $urandom_range(99);
        if (pick < 10) c = int'($signed(16'($urandom)));
        else if (pick < 13) c = int'(shadow_cfg.jam_threshold_ma);
        else if (pick < 16) c = int'(shadow_cfg.release_threshold_ma);
        else c = int'($urandom_range(1000)) - 500;
      end
      send_cmd(md, rq, fr, ang, 16'(c));
    end
  endtask

  // Window edges, every mode, burst of zero, equal currents, jam and recovery
  task automatic test_directed_cases();
    tx_idle_pct = 26;
    rx_idle_pct = 77;
    program_feeder(make_settings(1'b1, 1000, 2, 1, 500, 0, 0, 8192));
    send_cmd(MODE_SAFE, 1'b0, 1'b0, 16'h1000, 16'sd0);
    send_cmd(MODE_CONTINUOUS, 1'b1, 1'b0, 16'h1000, 16'sd0);
    send_cmd(MODE_CONTINUOUS, 1'b1, 1'b1, 16'h1000, 16'sd0);
    send_cmd(MODE_CONTINUOUS, 1'b1, 1'b1, 16'h1000 - ONE_RAD - 16'd1, 16'sd0);
    send_cmd(MODE_CONTINUOUS, 1'b1, 1'b1, 16'h1000 - ONE_RAD, 16'sd0);
    send_cmd(MODE_CONTINUOUS, 1'b1, 1'b1, 16'hB000, 16'sd0);
    send_cmd(MODE_CONTINUOUS, 1'b1, 1'b0, 16'h5000, 16'sd0);
    send_cmd(MODE_BURST, 1'b1, 1'b1, 16'h5000, 16'sd0);
    send_cmd(MODE_BURST, 1'b1, 1'b1, 16'h5000, 16'sd0);
    send_cmd(MODE_SINGLE, 1'b1, 1'b0, 16'h5000, 16'sd1000);
    send_cmd(MODE_SINGLE, 1'b1, 1'b1, 16'h5000, 16'sd1001);
    send_cmd(MODE_SINGLE, 1'b1, 1'b1, 16'h5000, 16'sd1000);
    send_cmd(MODE_SINGLE, 1'b1, 1'b1, 16'h0000, 16'h7FFF);
    send_cmd(MODE_SINGLE, 1'b1, 1'b1, 16'h0100, 16'sd500);
    send_cmd(MODE_SINGLE, 1'b1, 1'b1, 16'hFFFF, 16'sd500);
    send_cmd(MODE_SINGLE, 1'b1, 1'b1, 16'hFFFF, 16'h8000);
    send_cmd(MODE_SINGLE, 1'b0, 1'b0, 16'h0000, 16'sd0);
    send_cmd(MODE_SINGLE, 1'b0, 1'b0, 16'h0000, 16'sd0);
    send_cmd(MODE_SAFE, 1'b1, 1'b1, 16'hFFFF, 16'h7FFF);
    settle_feeder();
  endtask

  task automatic test_random_shooting(int tx, int rx, ffsjg_cfg_t first_cfg,
                                      ffsjg_cfg_t second_cfg, int n_each);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    program_feeder(first_cfg);
    drive_shooting(n_each);
    program_feeder(second_cfg);
    drive_shooting(n_each);
    settle_feeder();
  endtask

  // Hold the result side off for a long stretch while ticks keep coming
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_feeder(make_settings(1'b1, 2000, 3, 4, 1000, 2, 3, 8192));
    @(posedge clk);
    stall_left = 300;
    drive_shooting(50);
    settle_feeder();
  endtask

  initial begin
    ffsjg_cfg_t typical_cfg;
    ffsjg_cfg_t high_cfg;
    ffsjg_cfg_t low_cfg;
    ffsjg_cfg_t reset_cfg;
    rst_n                  = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.data            = '0;
    in_ch.valid            = 1'b0;
    in_ch.mode             = MODE_SAFE;
    in_ch.ready_req        = 1'b0;
    in_ch.fire             = 1'b0;
    in_ch.measured_angle   = '0;
    in_ch.motor_current_ma = '0;
    out_ch.ready           = 1'b0;
    reset_feeder_model();
    typical_cfg = make_settings(1'b1, 2000, 3, 4, 1000, 2, 3, 8192);
    high_cfg    = make_settings(1'b1, 32767, 65535, 65535, 32767, 65535, 255, 65535);
    low_cfg     = make_settings(1'b0, 0, 0, 0, 0, 0, 0, 0);
    reset_cfg   = make_settings(RST_JAM_ENABLE, RST_JAM_THRESHOLD, RST_JAM_SUSPECT,
                                RST_JAM_RECOVER, RST_RELEASE_THRESH, RST_SHOT_PERIOD,
                                RST_BURST_COUNT, RST_TOOTH_STEP);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_shooting(26, 77, typical_cfg, high_cfg, 100);
    test_random_shooting(77, 26, low_cfg, random_settings(), 100);
    test_random_shooting(0, 0, random_settings(), reset_cfg, 100);
    test_output_stall();

    if (mismatch_count == 0) begin
      $display("PASS feeder_fire_sequencer_jam_guard_unit");
    end else begin
      $display("FAIL feeder_fire_sequencer_jam_guard_unit");
    end
    $finish;
  end

endmodule

// ===== feeder_fire_sequencer_jam_guard_unit.f =====
+incdir+rtl
rtl/ffsjg_pkg.sv
rtl/ffsjg_if.sv
rtl/ffsjg_cfg_regs.sv
rtl/ffsjg_seq.sv
rtl/feeder_fire_sequencer_jam_guard_unit.sv
test/tb_feeder_fire_sequencer_jam_guard_unit.sv
